/* rtl/core/acmac_pkg.sv */
// ----------------------------------------------------------------------------
// acmac_pkg
// Shared types, constants and AES helper functions for the CMAC tag engine.
// ----------------------------------------------------------------------------
package acmac_pkg;

    localparam int QueueDepthDefault = 2;
    localparam logic [7:0] PadByte   = 8'h80;
    localparam logic [7:0] DoubleRed = 8'h87;
    localparam logic [4:0] BlockBytes = 5'd16;
    localparam logic [3:0] LastRound  = 4'd10;

    typedef enum logic [1:0] {
        CMD_ABSORB   = 2'd0,
        CMD_FINAL_K1 = 2'd1,
        CMD_FINAL_K2 = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t    kind;
        logic [127:0] blk;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DERIVE = 2'd1,
        ST_CRYPT  = 2'd2
    } back_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        unique case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // next round key, byte 0 in the top bits
    function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] tmp;
        logic [31:0] w0, w1, w2, w3;
        tmp = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        w0 = rk[127:96] ^ tmp;
        w1 = rk[95:64] ^ w0;
        w2 = rk[63:32] ^ w1;
        w3 = rk[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // sub bytes, shift rows and, unless final, mix columns
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            t[i] = SBOX[s[127 - 8 * ((i % 4) + 4 * (((i / 4) + (i % 4)) % 4)) -: 8]];
        end
        if (!final_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c];
                a1 = t[4 * c + 1];
                a2 = t[4 * c + 2];
                a3 = t[4 * c + 3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4 * c]     = a0 ^ all ^ xt(a0 ^ a1);
                t[4 * c + 1] = a1 ^ all ^ xt(a1 ^ a2);
                t[4 * c + 2] = a2 ^ all ^ xt(a2 ^ a3);
                t[4 * c + 3] = a3 ^ all ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = t[i];
        end
        return r;
    endfunction

endpackage

/* rtl/core/aes_cmac_tag_engine_unit.sv */
// ----------------------------------------------------------------------------
// aes_cmac_tag_engine_unit
// AES-128 CMAC over a byte stream, tag emitted on the last word.
// ----------------------------------------------------------------------------
// usage:
//   write key_high (index 0) and key_low (index 1) on the cfg port while idle
//   s_axis carries one message byte per word; tlast ends the message and
//   tuser set with tlast marks an end word that carries no byte
//   m_axis returns one 128-bit tag word per message
// throughput: the input takes one byte per cycle while the command queue has
//   room and no final block is pending; each 16-byte block costs the cipher
//   10 rounds plus load and hand-off, so long messages run at the full byte
//   rate; the input stalls after a last byte that opens a new block until
//   the final block is queued; the subkey derivation at the start of a message
//   costs another cipher pass, so messages under about two blocks are paced by
//   the cipher and the input stalls once the command queue fills
// tag path: the tag follows the final block through the cipher, after any due
//   subkeys and held-back full block; a waiting tag on the output adds its wait
// reset: clears the byte count, queue, cipher and message state; the key
//   registers reset to zero
// stall: a pending tag is held until taken; further final blocks wait behind
//   it, and the input stalls once the command queue fills
// ----------------------------------------------------------------------------
module aes_cmac_tag_engine_unit #(
    parameter int QueueDepth = acmac_pkg::QueueDepthDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tlast,   // last_byte
    input  logic         s_axis_tuser,   // no_data
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // tag_high [63:0], tag_low [127:64]
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data
);
    import acmac_pkg::*;

    localparam logic CfgKeyHigh = 1'b0;
    localparam logic CfgKeyLow  = 1'b1;

    logic [63:0]  key_hi_reg, key_lo_reg;
    q_flags_t     q_flags;
    logic         q_push, q_pop;
    cmd_t         q_cmd, q_head;
    logic [127:0] tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CfgKeyHigh: key_hi_reg <= cfg_data;
                CfgKeyLow:  key_lo_reg <= cfg_data;
                default:    key_hi_reg <= key_hi_reg;
            endcase
        end
    end

    acmac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .in_nodata (s_axis_tuser),
        .q_flags   (q_flags),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    acmac_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .flags    (q_flags)
    );

    acmac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_hi_reg, key_lo_reg}),
        .head      (q_head),
        .q_flags   (q_flags),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tag   (tag)
    );

    assign m_axis_tdata = {tag[63:0], tag[127:64]};

    // the packer never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_flags.full))
        else $error("push into full command queue");

    // the cipher side never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_flags.empty))
        else $error("pop from empty command queue");

    // input is only taken while the queue has room
    assert property (@(posedge clk) disable iff (!rst_n) s_axis_tready |-> !q_flags.full)
        else $error("input ready while queue full");

endmodule

/* rtl/core/acmac_front.sv */
// ----------------------------------------------------------------------------
// acmac_front
// Packs message bytes into 16-byte blocks and issues block commands.
// ----------------------------------------------------------------------------
module acmac_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic               in_nodata,
    input  acmac_pkg::q_flags_t q_flags,
    output logic               q_push,
    output acmac_pkg::cmd_t    q_cmd
);
    import acmac_pkg::*;

    logic [127:0] buf_reg, buf_next;
    logic [4:0]   fill_reg, fill_next;
    logic         pend_reg, pend_next;
    logic         accept;
    logic [3:0]   pos;
    logic [127:0] ins_buf;
    logic [4:0]   ins_cnt;

    function automatic cmd_t make_final(input logic [127:0] b, input logic [4:0] cnt);
        cmd_t c;
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < cnt)
                c.blk[127 - 8 * i -: 8] = b[127 - 8 * i -: 8];
            else if (5'(i) == cnt)
                c.blk[127 - 8 * i -: 8] = PadByte;
            else
                c.blk[127 - 8 * i -: 8] = 8'h00;
        end
        c.kind = (cnt == BlockBytes) ? CMD_FINAL_K1 : CMD_FINAL_K2;
        return c;
    endfunction

    assign in_ready = !pend_reg && !q_flags.full;
    assign accept   = in_valid && in_ready;
    // a full block is flushed when the next byte arrives, so the byte lands at 0
    assign pos      = (fill_reg == BlockBytes) ? 4'd0 : fill_reg[3:0];
    assign ins_cnt  = {1'b0, pos} + 5'd1;

    always_comb
    begin
        for (int i = 0; i < 16; i++) begin
            ins_buf[127 - 8 * i -: 8] = (pos == 4'(i)) ? in_byte : buf_reg[127 - 8 * i -: 8];
        end
    end

    always_comb
    begin
        buf_next  = buf_reg;
        fill_next = fill_reg;
        pend_next = pend_reg;
        q_push    = 1'b0;
        q_cmd     = make_final(buf_reg, fill_reg);
        if (pend_reg) begin
            if (!q_flags.full) begin
                q_push    = 1'b1;
                fill_next = 5'd0;
                pend_next = 1'b0;
            end
        end else if (accept) begin
            if (!in_nodata) begin
                buf_next  = ins_buf;
                fill_next = ins_cnt;
                if (fill_reg == BlockBytes) begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_ABSORB;
                    q_cmd.blk  = buf_reg;
                    pend_next  = in_last;
                end else if (in_last) begin
                    q_push    = 1'b1;
                    q_cmd     = make_final(ins_buf, ins_cnt);
                    fill_next = 5'd0;
                end
            end else if (in_last) begin
                q_push    = 1'b1;
                fill_next = 5'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg <= 5'd0;
            pend_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

/* rtl/core/acmac_queue.sv */
// ----------------------------------------------------------------------------
// acmac_queue
// Small command queue between the byte packer and the cipher side.
// ----------------------------------------------------------------------------
module acmac_queue #(
    parameter int Depth = acmac_pkg::QueueDepthDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  acmac_pkg::cmd_t     push_cmd,
    input  logic                pop,
    output acmac_pkg::cmd_t     head,
    output acmac_pkg::q_flags_t flags
);
    import acmac_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    cmd_t            mem_reg [Depth];
    logic [PtrW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign flags.full  = (cnt_reg == CntW'(Depth));
    assign flags.empty = (cnt_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head        = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PtrW'(Depth - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PtrW'(Depth - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_cmd;
    end

endmodule

/* rtl/core/acmac_aes.sv */
// ----------------------------------------------------------------------------
// acmac_aes
// Iterative AES-128 encryptor, one round per cycle, keys expanded on the fly.
// ----------------------------------------------------------------------------
module acmac_aes (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [127:0] din,
    output logic         done,
    output logic [127:0] dout
);
    import acmac_pkg::*;

    logic [127:0] st_reg, st_next, rk_reg, rk_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next, done_reg, done_next;
    logic [127:0] rk_step;

    assign rk_step = key_expand(rk_reg, rcon(rnd_reg));
    assign done    = done_reg;
    assign dout    = st_reg;

    always_comb
    begin
        st_next   = st_reg;
        rk_next   = rk_reg;
        rnd_next  = rnd_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            st_next   = din ^ key;
            rk_next   = key;
            rnd_next  = 4'd1;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            st_next  = aes_round(st_reg, rnd_reg == LastRound) ^ rk_step;
            rk_next  = rk_step;
            rnd_next = rnd_reg + 4'd1;
            if (rnd_reg == LastRound) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            rnd_reg  <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        rk_reg <= rk_next;
    end

endmodule

/* rtl/core/acmac_back.sv */
// ----------------------------------------------------------------------------
// acmac_back
// Derives subkeys, chains blocks through the cipher and holds the tag.
// ----------------------------------------------------------------------------
module acmac_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [127:0]        key,
    input  acmac_pkg::cmd_t     head,
    input  acmac_pkg::q_flags_t q_flags,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [127:0]        out_tag
);
    import acmac_pkg::*;

    back_state_t  st_reg, st_next;
    logic         in_msg_reg, in_msg_next;
    logic         fin_reg, fin_next;
    logic         ov_reg, ov_next;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] sk1_reg, sk1_next, sk2_reg, sk2_next;
    logic [127:0] tag_reg, tag_next;
    logic         aes_start, aes_done;
    logic [127:0] aes_din, aes_dout, sk_sel;

    function automatic logic [127:0] gf_double(input logic [127:0] a);
        return {a[126:0], 1'b0} ^ {120'd0, a[127] ? DoubleRed : 8'h00};
    endfunction

    acmac_aes u_aes (
        .clk   (clk),
        .rst_n (rst_n),
        .start (aes_start),
        .key   (key),
        .din   (aes_din),
        .done  (aes_done),
        .dout  (aes_dout)
    );

    assign out_valid = ov_reg;
    assign out_tag   = tag_reg;

    always_comb
    begin
        case (head.kind)
            CMD_FINAL_K1: sk_sel = sk1_reg;
            CMD_FINAL_K2: sk_sel = sk2_reg;
            default:      sk_sel = '0;
        endcase
    end

    always_comb
    begin
        st_next     = st_reg;
        in_msg_next = in_msg_reg;
        fin_next    = fin_reg;
        ov_next     = ov_reg && !out_ready;
        chain_next  = chain_reg;
        sk1_next    = sk1_reg;
        sk2_next    = sk2_reg;
        tag_next    = tag_reg;
        q_pop       = 1'b0;
        aes_start   = 1'b0;
        aes_din     = chain_reg ^ head.blk ^ sk_sel;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (!q_flags.empty) begin
                    if (!in_msg_reg) begin
                        aes_start = 1'b1;
                        aes_din   = '0;
                        st_next   = ST_DERIVE;
                    end else if (head.kind == CMD_ABSORB || !ov_reg) begin
                        // a final block waits until the tag slot is free
                        aes_start = 1'b1;
                        q_pop     = 1'b1;
                        fin_next  = (head.kind != CMD_ABSORB);
                        st_next   = ST_CRYPT;
                    end
                end
            end
            ST_DERIVE:
            begin
                if (aes_done) begin
                    sk1_next    = gf_double(aes_dout);
                    sk2_next    = gf_double(gf_double(aes_dout));
                    chain_next  = '0;
                    in_msg_next = 1'b1;
                    st_next     = ST_IDLE;
                end
            end
            ST_CRYPT:
            begin
                if (aes_done) begin
                    st_next = ST_IDLE;
                    if (fin_reg) begin
                        tag_next    = aes_dout;
                        ov_next     = 1'b1;
                        chain_next  = '0;
                        in_msg_next = 1'b0;
                    end else begin
                        chain_next = aes_dout;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg     <= ST_IDLE;
            in_msg_reg <= 1'b0;
            fin_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            chain_reg  <= '0;
        end else begin
            st_reg     <= st_next;
            in_msg_reg <= in_msg_next;
            fin_reg    <= fin_next;
            ov_reg     <= ov_next;
            chain_reg  <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sk1_reg <= sk1_next;
        sk2_reg <= sk2_next;
        tag_reg <= tag_next;
    end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the CMAC tag engine: a fixed table of messages, some
// with known tags, then random messages over several keys. Every word taken
// by the engine runs through an AES-128 CMAC predictor kept in this file, and
// each tag word is compared with the oldest queued tag, known or predicted.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic KEY_HIGH_REG = 1'b0;
    localparam logic KEY_LOW_REG  = 1'b1;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [7:0] GF_POLY  = 8'h87;
    localparam int ITEM_TARGET  = 1600;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 3000;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } tag_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       nodata;
        logic       rfc_key_first;  // drain and load the RFC 4493 key before this word
        logic       known;
        tag_t       tag;
    } plan_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;    // data_byte
    logic         s_axis_tlast = 1'b0;  // last_byte
    logic         s_axis_tuser = 1'b0;  // no_data
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;         // tag_high [63:0], tag_low [127:64]
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [63:0]  cfg_data = '0;

    aes_cmac_tag_engine_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor state
    logic [7:0]   sbox_tab [256];
    logic [63:0]  key_hi, key_lo;
    logic [127:0] chain, subkey1, subkey2;
    logic [7:0]   blk_bytes [16];
    int           fill;
    logic         in_msg;

    tag_t      tag_expect_q [$];
    plan_row_t plan [$];
    int  errors = 0;
    int  mismatches = 0;
    int  counted_items = 0;
    logic calm = 1'b0;
    logic hold_long = 1'b0;
    logic run_done = 1'b0;
    logic in_accept, out_accept;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] times2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = times2(a);
        end
        return p;
    endfunction

    function automatic logic [127:0] aes_encrypt_block(input logic [127:0] key,
                                                      input logic [127:0] pt);
        logic [7:0] st [16];
        logic [7:0] sh [16];
        logic [7:0] rk [16];
        logic [7:0] tw [4];
        logic [7:0] a0, a1, a2, a3, all, rc;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127 - 8 * i -: 8];
            st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
        end
        rc = 8'h01;
        for (int r = 1; r <= 10; r++) begin
            tw[0] = sbox_tab[rk[13]] ^ rc;
            tw[1] = sbox_tab[rk[14]];
            tw[2] = sbox_tab[rk[15]];
            tw[3] = sbox_tab[rk[12]];
            for (int i = 0; i < 16; i++) begin
                rk[i] = rk[i] ^ ((i < 4) ? tw[i] : rk[i - 4]);
            end
            rc = times2(rc);
            for (int i = 0; i < 16; i++) begin
                sh[i] = sbox_tab[st[(i % 4) + 4 * (((i / 4) + (i % 4)) % 4)]];
            end
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = sh[4 * c];
                    a1 = sh[4 * c + 1];
                    a2 = sh[4 * c + 2];
                    a3 = sh[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    sh[4 * c]     = a0 ^ all ^ times2(a0 ^ a1);
                    sh[4 * c + 1] = a1 ^ all ^ times2(a1 ^ a2);
                    sh[4 * c + 2] = a2 ^ all ^ times2(a2 ^ a3);
                    sh[4 * c + 3] = a3 ^ all ^ times2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) begin
                st[i] = sh[i] ^ rk[i];
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127 - 8 * i -: 8] = st[i];
        end
        return res;
    endfunction

    function automatic logic [127:0] gf_double(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ (v[127] ? {120'd0, GF_POLY} : 128'd0);
    endfunction

    // cmac state update for one accepted word
    task automatic cmac_take_word(input logic [7:0] data, input logic last,
                                  input logic nodata, output logic has_tag,
                                  output tag_t tag);
        logic [127:0] blk;
        has_tag = 1'b0;
        tag = '0;
        if (nodata && !last) return;
        if (!in_msg) begin
            subkey1 = gf_double(aes_encrypt_block({key_hi, key_lo}, 128'd0));
            subkey2 = gf_double(subkey1);
            chain = '0;
            fill = 0;
            in_msg = 1'b1;
        end
        if (!nodata) begin
            // a full block is only absorbed once it is known not to be final
            if (fill == 16) begin
                for (int i = 0; i < 16; i++) blk[127 - 8 * i -: 8] = blk_bytes[i];
                chain = aes_encrypt_block({key_hi, key_lo}, chain ^ blk);
                fill = 0;
            end
            blk_bytes[fill] = data;
            fill++;
        end
        if (!last) return;
        for (int i = 0; i < 16; i++) begin
            blk[127 - 8 * i -: 8] = (i < fill) ? blk_bytes[i] : ((i == fill) ? PAD_MARK : 8'h00);
        end
        blk ^= (fill == 16) ? subkey1 : subkey2;
        chain = aes_encrypt_block({key_hi, key_lo}, chain ^ blk);
        tag = {chain[127:64], chain[63:0]};
        has_tag = 1'b1;
        chain = '0;
        fill = 0;
        in_msg = 1'b0;
    endtask

    task automatic send_word(input logic [7:0] data, input logic last, input logic nodata,
                             input logic known, input tag_t known_tag);
        logic has_tag;
        tag_t tag;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        s_axis_tuser  <= nodata;
        do @(posedge clk); while (!s_axis_tready);
        cmac_take_word(data, last, nodata, has_tag, tag);
        if (has_tag) tag_expect_q.push_back(known ? known_tag : tag);
        if (!(nodata && !last)) counted_items++;
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain_and_load_key(input logic [63:0] hi, input logic [63:0] lo);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tag_expect_q.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= KEY_HIGH_REG;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= KEY_LOW_REG;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_we <= 1'b0;
        key_hi = hi;
        key_lo = lo;
    endtask

    task automatic send_message();
        int len;
        logic marker;
        len = $urandom_range(0, 40);
        if ($urandom_range(0, 3) == 0) len = 16 * $urandom_range(1, 4);
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(41, 100);
        marker = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
            sender_gap();
            send_word(8'($urandom), !marker && (i == len - 1), 1'b0, 1'b0, '0);
        end
        if (marker) begin
            sender_gap();
            send_word(8'($urandom), 1'b1, 1'b1, 1'b0, '0);
        end
    endtask

    function automatic void add_row(input logic [7:0] data, input logic last,
                                    input logic nodata, input logic rekey,
                                    input logic known, input tag_t tag);
        plan_row_t row;
        row.data = data;
        row.last = last;
        row.nodata = nodata;
        row.rfc_key_first = rekey;
        row.known = known;
        row.tag = tag;
        plan.push_back(row);
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial begin
        int stall;
        int hold_count;
        stall = 0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (tag_expect_q.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected tag word %h", m_axis_tdata);
                end else begin
                    tag_t want;
                    want = tag_expect_q.pop_front();
                    if (m_axis_tdata[63:0] !== want.hi || m_axis_tdata[127:64] !== want.lo) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("tag mismatch: expected hi %h lo %h, got hi %h lo %h",
                                     want.hi, want.lo, m_axis_tdata[63:0], m_axis_tdata[127:64]);
                    end
                end
            end
            if (hold_long) begin
                hold_count = LONG_HOLD;
                hold_long = 1'b0;
            end
            if (hold_count > 0) begin
                hold_count--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;

    initial begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            quiet = (in_accept || out_accept || cfg_we) ? 0 : quiet + 1;
            if (quiet >= STALL_LIMIT && !run_done) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        logic [127:0] rfc_msg;
        logic [7:0] b;
        int phase_goal;
        tag_t no_tag;
        no_tag = '0;
        rfc_msg = 128'h6bc1bee22e409f96e93d7e117393172a;
        for (int x = 0; x < 256; x++) begin
            b = 8'h00;
            for (int y = 1; y < 256 && x != 0; y++) begin
                if (gf_mul(x[7:0], y[7:0]) == 8'h01) b = y[7:0];
            end
            sbox_tab[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                        ^ {b[3:0], b[7:4]} ^ 8'h63;
        end
        key_hi = '0;
        key_lo = '0;
        chain = '0;
        fill = 0;
        in_msg = 1'b0;

        // zero key after reset: ignored word, empty message, single bytes
        add_row(8'h5a, 1'b0, 1'b1, 1'b0, 1'b0, no_tag);
        add_row(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, no_tag);
        add_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, no_tag);
        add_row(8'hff, 1'b1, 1'b0, 1'b0, 1'b0, no_tag);
        // published key: empty message and one full block
        add_row(8'h00, 1'b1, 1'b1, 1'b1, 1'b1,
                {64'hbb1d6929e9593728, 64'h7fa37d129b756746});
        for (int i = 0; i < 16; i++) begin
            add_row(rfc_msg[127 - 8 * i -: 8], i == 15, 1'b0, 1'b0, i == 15,
                    {64'h070a16b46b4d4144, 64'hf79bdd9dd04a287c});
        end
        // end marker after a partial block and a stray no-byte word
        add_row(8'h01, 1'b0, 1'b0, 1'b0, 1'b0, no_tag);
        add_row(8'h33, 1'b0, 1'b1, 1'b0, 1'b0, no_tag);
        add_row(8'h80, 1'b1, 1'b1, 1'b0, 1'b0, no_tag);

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].rfc_key_first)
                drain_and_load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
            send_word(plan[i].data, plan[i].last, plan[i].nodata, plan[i].known, plan[i].tag);
        end

        // random part: one phase per key, all-ones first, zero key last and calm
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: drain_and_load_key('1, '1);
                1: drain_and_load_key('0, {$urandom, $urandom});
                4: drain_and_load_key('0, '0);
                default: drain_and_load_key({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            if (phase == 4) calm = 1'b1;
            if (phase == 2) hold_long = 1'b1;
            phase_goal = counted_items + ITEM_TARGET / 5;
            while (counted_items < phase_goal) send_message();
        end

        s_axis_tvalid <= 1'b0;
        while (tag_expect_q.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        run_done = 1'b1;
        if (errors == 0 && tag_expect_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

/* aes_cmac_tag_engine_unit.f */
rtl/core/acmac_pkg.sv
rtl/core/acmac_front.sv
rtl/core/acmac_queue.sv
rtl/core/acmac_aes.sv
rtl/core/acmac_back.sv
rtl/core/aes_cmac_tag_engine_unit.sv
verif/testbench.sv
